>>> rtl/tte_pkg.sv
// Shared constants, codes and beat types for the timer table expiry engine.
package tte_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int SLOT_W     = 4;
   localparam int TIME_W     = 64;
   localparam int KIND_W     = 2;

   localparam logic CMD_ARM  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [KIND_W-1:0] KIND_ARM     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELAY   = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_BUSY = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              status;
      logic [SLOT_W-1:0] expired_slot;
      logic [TIME_W-1:0] next_delay;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  slot;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] now;
   } scan_req_type;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  slot;
      logic              expired;
      logic [TIME_W-1:0] delay;
   } scan_rsp_type;

endpackage

>>> rtl/tte_dsub.sv
// Shared deadline subtractor: one registered deadline-minus-now with expiry flag.
module tte_dsub (
   input  logic                  clock,
   input  logic                  reset,
   input  tte_pkg::scan_req_type scan_req,
   output tte_pkg::scan_rsp_type scan_rsp
);

   logic [tte_pkg::TIME_W:0] diff;
   tte_pkg::scan_rsp_type    out_ff;
   tte_pkg::scan_rsp_type    out_in;

   always_comb begin
      diff            = {1'b0, scan_req.deadline} - {1'b0, scan_req.now};
      out_in.valid    = scan_req.valid;
      out_in.slot     = scan_req.slot;
      out_in.expired  = diff[tte_pkg::TIME_W] || (diff[tte_pkg::TIME_W-1:0] == '0);
      out_in.delay    = diff[tte_pkg::TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.slot    <= out_in.slot;
      out_ff.expired <= out_in.expired;
      out_ff.delay   <= out_in.delay;
   end

   assign scan_rsp = out_ff;

endmodule

>>> rtl/timer_table_expiry_engine_unit.sv
// Top level of the timer table expiry engine: slot table, arm order list and tick sequencer.
//
// An arm command is taken while idle: busy stays low and its status beat appears on
// the following cycle. A tick raises busy while a walk reads one deadline per cycle
// from the deadline table, newest armed first, through the shared 64-bit subtractor
// (the read and the subtract are each registered), and while a compaction pass then
// rewrites the arm order list one entry per cycle. Expired-slot beats stream out during
// the walk, the next-delay beat (last set) at its end. Every result beat is strobed for
// exactly one cycle; the receiver cannot stall.
module timer_table_expiry_engine_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tte_pkg::req_type req,
   output logic             rsp_strobe,
   output tte_pkg::rsp_type rsp
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_PACK  = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [tte_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [tte_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic [tte_pkg::CNT_W-1:0]     keep_ff, keep_in;
   logic [tte_pkg::TIME_W-1:0]    now_ff, now_in;
   logic [tte_pkg::TIME_W-1:0]    best_ff, best_in;
   logic [tte_pkg::NUM_TIMERS-1:0] armed_ff, armed_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [tte_pkg::IDX_W-1:0]     rd_slot_ff;
   logic [tte_pkg::TIME_W-1:0]    dl_rd_ff;
   tte_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          strobe_ff, strobe_in;

   logic [tte_pkg::IDX_W-1:0]     order_ff [tte_pkg::NUM_TIMERS];
   logic [tte_pkg::TIME_W-1:0]    dl_mem   [tte_pkg::NUM_TIMERS];

   logic                          accept;
   logic                          arm_do;
   logic [tte_pkg::IDX_W-1:0]     slot_idx;
   logic                          slot_in_range;
   logic [tte_pkg::IDX_W-1:0]     rd_addr;
   logic [tte_pkg::IDX_W-1:0]     order_rd;
   logic                          rd_issue;
   logic                          order_we;
   logic [tte_pkg::IDX_W-1:0]     order_wa;
   logic [tte_pkg::IDX_W-1:0]     order_wd;
   logic [tte_pkg::CNT_W-1:0]     idx_dec;
   tte_pkg::scan_req_type         scan_req;
   tte_pkg::scan_rsp_type         scan_rsp;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign slot_idx = tte_pkg::IDX_W'(req.slot);
   assign slot_in_range = (32'(req.slot) < 32'(tte_pkg::NUM_TIMERS));
   assign idx_dec  = idx_ff - tte_pkg::CNT_W'(1);
   assign order_rd = order_ff[rd_addr];

   assign scan_req.valid    = rd_valid_ff;
   assign scan_req.slot     = rd_slot_ff;
   assign scan_req.deadline = dl_rd_ff;
   assign scan_req.now      = now_ff;

   tte_dsub u_dsub (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      keep_in     = keep_ff;
      now_in      = now_ff;
      best_in     = best_ff;
      armed_in    = armed_ff;
      rd_valid_in = 1'b0;
      rsp_in      = '0;
      strobe_in   = 1'b0;
      arm_do      = 1'b0;
      rd_issue    = 1'b0;
      rd_addr     = idx_ff[tte_pkg::IDX_W-1:0];
      order_we    = 1'b0;
      order_wa    = count_ff[tte_pkg::IDX_W-1:0];
      order_wd    = slot_idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.cmd == tte_pkg::CMD_ARM) begin
                  rsp_in.kind   = tte_pkg::KIND_ARM;
                  rsp_in.status = tte_pkg::STATUS_BUSY;
                  rsp_in.last   = 1'b1;
                  strobe_in     = 1'b1;
                  if (slot_in_range && !armed_ff[slot_idx] &&
                      (count_ff < tte_pkg::CNT_W'(tte_pkg::NUM_TIMERS))) begin
                     arm_do             = 1'b1;
                     armed_in[slot_idx] = 1'b1;
                     order_we           = 1'b1;
                     count_in           = count_ff + tte_pkg::CNT_W'(1);
                     rsp_in.status      = tte_pkg::STATUS_OK;
                  end
               end else begin
                  now_in   = req.now;
                  best_in  = '1;
                  idx_in   = count_ff;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (idx_ff != '0) begin
               idx_in      = idx_dec;
               rd_addr     = idx_dec[tte_pkg::IDX_W-1:0];
               rd_issue    = 1'b1;
               rd_valid_in = 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !scan_rsp.valid) begin
               rsp_in.kind       = tte_pkg::KIND_DELAY;
               rsp_in.next_delay = best_ff;
               rsp_in.last       = 1'b1;
               strobe_in         = 1'b1;
               idx_in            = '0;
               keep_in           = '0;
               state_in          = ST_PACK;
            end
         end
         ST_PACK: begin
            if (idx_ff == count_ff) begin
               count_in = keep_ff;
               state_in = ST_IDLE;
            end else begin
               if (armed_ff[order_rd]) begin
                  order_we = 1'b1;
                  order_wa = keep_ff[tte_pkg::IDX_W-1:0];
                  order_wd = order_rd;
                  keep_in  = keep_ff + tte_pkg::CNT_W'(1);
               end
               idx_in = idx_ff + tte_pkg::CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (scan_rsp.valid) begin
         if (scan_rsp.expired) begin
            armed_in[scan_rsp.slot] = 1'b0;
            rsp_in.kind             = tte_pkg::KIND_EXPIRED;
            rsp_in.expired_slot     = tte_pkg::SLOT_W'(scan_rsp.slot);
            strobe_in               = 1'b1;
         end else if (scan_rsp.delay < best_ff) begin
            best_in = scan_rsp.delay;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         idx_ff      <= '0;
         keep_ff     <= '0;
         now_ff      <= '0;
         armed_ff    <= '0;
         rd_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         keep_ff     <= keep_in;
         now_ff      <= now_in;
         armed_ff    <= armed_in;
         rd_valid_ff <= rd_valid_in;
         strobe_ff   <= strobe_in;
      end
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_ff[order_wa] <= order_wd;
      end
      if (rd_issue) begin
         rd_slot_ff <= order_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (arm_do) begin
         dl_mem[slot_idx] <= req.deadline;
      end
      if (rd_issue) begin
         dl_rd_ff <= dl_mem[order_rd];
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

>>> rtl/tte_chk.sv
// Port-level checker for the timer table expiry engine, with its bind.
module tte_chk (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input tte_pkg::req_type req,
   input logic             rsp_strobe,
   input tte_pkg::rsp_type rsp
);

   a_arm_beat: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req.cmd == tte_pkg::CMD_ARM)
      |=> rsp_strobe && (rsp.kind == tte_pkg::KIND_ARM) && rsp.last)
      else $error("arm beat missing");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req.cmd == tte_pkg::CMD_TICK) |=> busy)
      else $error("tick did not raise busy");

   a_expired_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp.kind == tte_pkg::KIND_EXPIRED) |-> busy && !rsp.last)
      else $error("expired beat outside tick or marked last");

   a_delay_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp.kind == tte_pkg::KIND_DELAY) |-> busy && rsp.last)
      else $error("delay beat outside tick or not last");

endmodule

bind timer_table_expiry_engine_unit tte_chk u_tte_chk (.*);
